[rtl/mrf_pkg.sv]
package mrf_pkg;

    localparam int FRAME_LEN = 8;
    localparam int BODY_LEN  = 6;

    localparam logic [2:0]  IDX_CRC_LO = 3'(BODY_LEN);
    localparam logic [2:0]  IDX_CRC_HI = 3'(FRAME_LEN - 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Register map: index taken from paddr[2]
    localparam logic REG_WRITE_FC = 1'b0;
    localparam logic REG_READ_FC  = 1'b1;

    localparam logic [7:0] WRITE_FC_RESET = 8'd6;
    localparam logic [7:0] READ_FC_RESET  = 8'd3;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef struct packed {
        logic [7:0] write_fc;
        logic [7:0] read_fc;
    } t_cfg;

    // One request with the function code already resolved
    typedef struct packed {
        logic [7:0]  slave_address;
        logic [7:0]  func_code;
        logic [15:0] register_address;
        logic [15:0] data_word;
    } t_req;

    // CRC-16/Modbus, one byte: eight reflected shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/mrf_cfg_regs.sv]
module mrf_cfg_regs
    import mrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.write_fc <= WRITE_FC_RESET;
            r_cfg.read_fc  <= READ_FC_RESET;
        end else if (wr_en) begin
            if (paddr[2] == REG_READ_FC) begin
                r_cfg.read_fc <= pwdata[7:0];
            end else begin
                r_cfg.write_fc <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_READ_FC) begin
            prdata = {24'h000000, r_cfg.read_fc};
        end else begin
            prdata = {24'h000000, r_cfg.write_fc};
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/mrf_req_buf.sv]
module mrf_req_buf
    import mrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [7:0]  i_slave_address,
    input  logic        i_func,
    input  logic [15:0] i_register_address,
    input  logic [15:0] i_data_word,
    input  t_cfg        i_cfg,
    input  logic        i_take,
    output logic        o_busy,
    output logic        o_vld,
    output t_req        o_req
);

    logic r_vld;
    t_req r_req;
    logic load;

    assign load = i_start & ~r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_req.slave_address    <= i_slave_address;
            r_req.func_code        <= (i_func == FUNC_READ) ? i_cfg.read_fc : i_cfg.write_fc;
            r_req.register_address <= i_register_address;
            r_req.data_word        <= i_data_word;
        end
    end

    assign o_busy = r_vld;
    assign o_vld  = r_vld;
    assign o_req  = r_req;

    // a held request is never dropped before the serializer takes it
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !i_take |=> r_vld && $stable(r_req))
        else $error("pending request lost or changed");

endmodule

[rtl/mrf_serializer.sv]
module mrf_serializer
    import mrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_vld,
    input  t_req       i_req,
    output logic       o_take,
    output logic       o_strobe,
    output logic [7:0] o_frame_byte,
    output logic       o_last_byte
);

    logic        r_act;
    logic [2:0]  r_idx;
    logic [47:0] r_shift;
    logic [15:0] r_crc;
    logic        r_strobe;
    logic        r_last;
    logic [7:0]  r_byte;

    logic        n_act;
    logic [2:0]  n_idx;
    logic [47:0] n_shift;
    logic [15:0] n_crc;
    logic [7:0]  cur_byte;
    logic        take;
    logic        at_end;

    assign at_end = (r_idx == IDX_CRC_HI);
    assign take   = i_vld & (~r_act | at_end);

    always_comb begin
        if (r_idx == IDX_CRC_LO) begin
            cur_byte = r_crc[7:0];
        end else if (r_idx == IDX_CRC_HI) begin
            cur_byte = r_crc[15:8];
        end else begin
            cur_byte = r_shift[47:40];
        end
    end

    always_comb begin
        n_act   = r_act;
        n_idx   = r_idx;
        n_shift = r_shift;
        n_crc   = r_crc;
        if (take) begin
            n_act   = 1'b1;
            n_idx   = 3'd0;
            n_shift = {i_req.slave_address, i_req.func_code,
                       i_req.register_address, i_req.data_word};
            n_crc   = CRC_INIT;
        end else if (r_act) begin
            n_act   = ~at_end;
            n_idx   = r_idx + 3'd1;
            n_shift = r_shift << 8;
            if (r_idx < IDX_CRC_LO) begin
                n_crc = crc16_byte(r_crc, r_shift[47:40]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_idx    <= 3'd0;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_act    <= n_act;
            r_idx    <= n_idx;
            r_strobe <= r_act;
            r_last   <= r_act & at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_crc   <= n_crc;
        r_byte  <= cur_byte;
    end

    assign o_take       = take;
    assign o_strobe     = r_strobe;
    assign o_frame_byte = r_byte;
    assign o_last_byte  = r_last;

    a_last_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last |-> r_strobe)
        else $error("last byte flag without strobe");

    a_frame_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && !r_last |=> r_strobe)
        else $error("gap inside a frame");

    a_idle_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act && at_end && !i_vld |=> !r_act && r_last)
        else $error("frame did not close after the CRC high byte");

endmodule

[rtl/modbus_rtu_request_framer.sv]
// Modbus RTU request framer.
// Command channel: drive the request fields and raise start; the request is
// taken at a clock edge with start high and busy low. Result channel: the
// eight-byte frame leaves one byte per cycle on o_frame_byte with o_strobe
// high for exactly one cycle per byte: slave address, function code,
// register address high/low, data word high/low, CRC-16/Modbus low/high.
// o_last_byte marks the CRC high byte. The receiver cannot hold bytes off.
// An accepted request passes the request buffer and the serializer registers
// before its first byte leaves the output byte register. Frames are paced by
// the serializer's single byte lane. A one-entry request buffer lets the next
// request be taken while the current frame is still going out, so frames run
// back to back; the CRC advances one byte per cycle as body bytes are sent.
// APB port: register 0 (address 0) is the write-single-register function
// code, reset 6; register 1 (address 4) the read-registers code, reset 3.
// Reset (synchronous, active low) empties the buffer, drops any frame in
// flight and restores both function codes.
module modbus_rtu_request_framer
    import mrf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_slave_address,
    input  logic        i_func,
    input  logic [15:0] i_register_address,
    input  logic [15:0] i_data_word,
    output logic        o_strobe,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg cfg;
    t_req req;
    logic req_vld;
    logic req_take;

    // function code registers
    mrf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // hold one pending request, function code resolved on capture
    mrf_req_buf u_buf (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_slave_address    (i_slave_address),
        .i_func             (i_func),
        .i_register_address (i_register_address),
        .i_data_word        (i_data_word),
        .i_cfg              (cfg),
        .i_take             (req_take),
        .o_busy             (busy),
        .o_vld              (req_vld),
        .o_req              (req)
    );

    // emit the frame one beat per cycle, CRC folded in as bytes pass
    mrf_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (req_vld),
        .i_req        (req),
        .o_take       (req_take),
        .o_strobe     (o_strobe),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte)
    );

endmodule
